FILE: sv/ffea_pkg.sv
// ----------------------------------------------------------------------------
// First-fit extent allocator package
// Status codes, request kinds and the control structs shared by the modules.
// ----------------------------------------------------------------------------
package ffea_pkg;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_FREE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NO_FIT   = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Control from the sequencer to the scan head.
   typedef struct packed {
      logic init;
      logic run;
      logic last;
      logic x_valid;
      logic full;
      logic is_free;
   } ffea_ctl_type;

   // Outcome of one pass, as seen by the sequencer.
   typedef struct packed {
      logic [1:0] status;
      logic       grow;
      logic       shrink;
   } ffea_res_type;

endpackage

FILE: sv/ffea_cell.sv
// ----------------------------------------------------------------------------
// Extent cell
// Holds one extent (start, size) and passes it to the next cell on shift.
// ----------------------------------------------------------------------------
module ffea_cell #(
   parameter int ADDR_BITS = 20
) (
   input  logic                 clock,
   input  logic                 shift,
   input  logic [ADDR_BITS-1:0] prev_start,
   input  logic [ADDR_BITS:0]   prev_size,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS:0]   size
);

   logic [ADDR_BITS-1:0] start_ff;
   logic [ADDR_BITS:0]   size_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         start_ff <= prev_start;
         size_ff  <= prev_size;
      end
   end

   assign start = start_ff;
   assign size  = size_ff;

endmodule

FILE: sv/ffea_head.sv
// ----------------------------------------------------------------------------
// Extent scan head
// Sits at the end of the cell chain and rewrites the extent stream as it
// circulates: shrinks, merges, inserts or drops one extent per request.
// ----------------------------------------------------------------------------
module ffea_head #(
   parameter int ADDR_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ffea_pkg::ffea_ctl_type ctl,
   input  logic [ADDR_BITS-1:0]  base,
   input  logic [ADDR_BITS:0]    length,
   input  logic [ADDR_BITS-1:0]  x_start,
   input  logic [ADDR_BITS:0]    x_size,
   output logic [ADDR_BITS-1:0]  y_start,
   output logic [ADDR_BITS:0]    y_size,
   output ffea_pkg::ffea_res_type res,
   output logic [ADDR_BITS-1:0]  alloc_base
);

   localparam int EW = ADDR_BITS + 2;

   typedef enum logic [1:0] {M_NORMAL, M_SKIP, M_INSERT} mode_type;

   mode_type             mode_ff, mode_in;
   logic                 done_ff, done_in;
   logic                 hv_ff, hv_in, cv_ff, cv_in;
   logic [ADDR_BITS-1:0] hs_ff, hs_in, cs_ff, cs_in;
   logic [ADDR_BITS:0]   hz_ff, hz_in, cz_ff, cz_in;
   logic [1:0]           status_ff, status_in;
   logic                 grow_ff, grow_in, shrink_ff, shrink_in;
   logic [ADDR_BITS-1:0] abase_ff, abase_in;

   logic [EW-1:0] end_w, h_end;
   logic          bad_req, join_lo, join_hi;

   assign end_w   = EW'(base) + EW'(length);
   assign h_end   = EW'(hs_ff) + EW'(hz_ff);
   assign bad_req = (length == '0) || (end_w > (EW'(1) << ADDR_BITS));
   assign join_lo = hv_ff && (h_end == EW'(base));
   assign join_hi = ctl.x_valid && (EW'(x_start) == end_w);

   always_comb begin
      mode_in   = mode_ff;
      done_in   = done_ff;
      hv_in     = hv_ff;
      hs_in     = hs_ff;
      hz_in     = hz_ff;
      cv_in     = cv_ff;
      cs_in     = cs_ff;
      cz_in     = cz_ff;
      status_in = status_ff;
      grow_in   = grow_ff;
      shrink_in = shrink_ff;
      abase_in  = abase_ff;
      y_start   = hs_ff;
      y_size    = hz_ff;
      if (ctl.init) begin
         mode_in   = M_NORMAL;
         hv_in     = 1'b0;
         cv_in     = 1'b0;
         grow_in   = 1'b0;
         shrink_in = 1'b0;
         abase_in  = '0;
         if (ctl.is_free) begin
            done_in   = bad_req;
            status_in = bad_req ? ffea_pkg::ST_BAD_FREE : ffea_pkg::ST_OK;
         end else begin
            done_in   = (length == '0);
            status_in = ffea_pkg::ST_NO_FIT;
         end
      end else if (ctl.run) begin
         unique case (mode_ff)
            M_NORMAL: begin
               hs_in = x_start;
               hz_in = x_size;
               hv_in = ctl.x_valid;
               if (!done_ff && !ctl.is_free && ctl.x_valid && (x_size >= length)) begin
                  done_in   = 1'b1;
                  status_in = ffea_pkg::ST_OK;
                  abase_in  = x_start;
                  if (x_size == length) begin
                     mode_in   = M_SKIP;
                     shrink_in = 1'b1;
                  end else begin
                     hs_in = x_start + length[ADDR_BITS-1:0];
                     hz_in = x_size - length;
                  end
               end else if (!done_ff && ctl.is_free &&
                            (!ctl.x_valid || (x_start >= base))) begin
                  done_in = 1'b1;
                  if ((hv_ff && (h_end > EW'(base))) ||
                      (ctl.x_valid && (EW'(x_start) < end_w))) begin
                     status_in = ffea_pkg::ST_BAD_FREE;
                  end else if (join_lo && join_hi) begin
                     y_size    = hz_ff + length + x_size;
                     mode_in   = M_SKIP;
                     shrink_in = 1'b1;
                  end else if (join_lo) begin
                     y_size = hz_ff + length;
                  end else if (join_hi) begin
                     hs_in = base;
                     hz_in = x_size + length;
                  end else if (ctl.full) begin
                     status_in = ffea_pkg::ST_FULL;
                  end else begin
                     hs_in   = base;
                     hz_in   = length;
                     hv_in   = 1'b1;
                     cs_in   = x_start;
                     cz_in   = x_size;
                     cv_in   = ctl.x_valid;
                     mode_in = M_INSERT;
                     grow_in = 1'b1;
                  end
               end
            end
            M_SKIP: begin
               y_start = x_start;
               y_size  = x_size;
            end
            M_INSERT: begin
               hs_in = cs_ff;
               hz_in = cz_ff;
               hv_in = cv_ff;
               cs_in = x_start;
               cz_in = x_size;
               cv_in = ctl.x_valid;
            end
            default: begin
               y_start = hs_ff;
            end
         endcase
         // The hold slot leads the ring; it is always empty between passes.
         if (ctl.last) begin
            hv_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_NORMAL;
         done_ff   <= 1'b0;
         hv_ff     <= 1'b0;
         cv_ff     <= 1'b0;
         status_ff <= ffea_pkg::ST_OK;
         grow_ff   <= 1'b0;
         shrink_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         done_ff   <= done_in;
         hv_ff     <= hv_in;
         cv_ff     <= cv_in;
         status_ff <= status_in;
         grow_ff   <= grow_in;
         shrink_ff <= shrink_in;
      end
      hs_ff    <= hs_in;
      hz_ff    <= hz_in;
      cs_ff    <= cs_in;
      cz_ff    <= cz_in;
      abase_ff <= abase_in;
   end

   assign res.status = status_ff;
   assign res.grow   = grow_ff;
   assign res.shrink = shrink_ff;
   assign alloc_base = abase_ff;

endmodule

FILE: sv/first_fit_extent_allocator.sv
// After a request is accepted the block steps through S_PREP, S_RUN and S_FIN;
// rsp_tvalid rises once S_FIN has loaded the response. Each transaction takes one full turn
// of the extent ring through the scan head plus setup and result states; no new request is taken before that pass ends.
// A new request is taken while the previous response still waits.
// Reset (synchronous, active high) empties the extent table; cell contents
// stay undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
// First-fit extent allocator
// Free extents circulate through a ring of cells and a scan head that
// allocates first-fit and frees with coalescing of neighbors.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator #(
   parameter int MAX_EXTENTS = 64,
   parameter int ADDR_BITS   = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // base [ADDR_BITS-1:0], length [2*ADDR_BITS:ADDR_BITS], zero padding
   input  logic [((2*ADDR_BITS+1+7)/8)*8-1:0] req_tdata,
   // func
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // alloc_base [ADDR_BITS-1:0], zero padding
   output logic [((ADDR_BITS+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);

   localparam int CW  = $clog2(MAX_EXTENTS + 1);
   localparam int RQW = ((2*ADDR_BITS+1+7)/8)*8;
   localparam int RSW = ((ADDR_BITS+7)/8)*8;

   typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN, S_FIN} state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        k_ff, k_in, count_ff, count_in;
   logic                 func_ff;
   logic [ADDR_BITS-1:0] base_ff;
   logic [ADDR_BITS:0]   length_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0] rsp_base_ff;
   logic [1:0]           rsp_status_ff;
   logic                 req_take, rsp_load;

   ffea_pkg::ffea_ctl_type ctl;
   ffea_pkg::ffea_res_type res;
   logic [ADDR_BITS-1:0]   y_start, alloc_base;
   logic [ADDR_BITS:0]     y_size;
   logic [ADDR_BITS-1:0]   chain_start [MAX_EXTENTS+1];
   logic [ADDR_BITS:0]     chain_size  [MAX_EXTENTS+1];

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_load   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   assign ctl.init    = (state_ff == S_PREP);
   assign ctl.run     = (state_ff == S_RUN);
   assign ctl.last    = (k_ff == CW'(MAX_EXTENTS));
   assign ctl.x_valid = (k_ff < count_ff);
   assign ctl.full    = (count_ff == CW'(MAX_EXTENTS));
   assign ctl.is_free = (func_ff == ffea_pkg::FUNC_FREE);

   assign chain_start[0] = y_start;
   assign chain_size[0]  = y_size;

   for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
      ffea_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
         .clock      (clock),
         .shift      (ctl.run),
         .prev_start (chain_start[i]),
         .prev_size  (chain_size[i]),
         .start      (chain_start[i+1]),
         .size       (chain_size[i+1])
      );
   end

   ffea_head #(.ADDR_BITS(ADDR_BITS)) u_head (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .base       (base_ff),
      .length     (length_ff),
      .x_start    (chain_start[MAX_EXTENTS]),
      .x_size     (chain_size[MAX_EXTENTS]),
      .y_start    (y_start),
      .y_size     (y_size),
      .res        (res),
      .alloc_base (alloc_base)
   );

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            k_in     = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            k_in = k_ff + CW'(1);
            if (ctl.last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (res.grow) begin
                  count_in = count_ff + CW'(1);
               end else if (res.shrink) begin
                  count_in = count_ff - CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_take) begin
         func_ff   <= req_tuser;
         base_ff   <= req_tdata[ADDR_BITS-1:0];
         length_ff <= req_tdata[2*ADDR_BITS:ADDR_BITS];
      end
      if (rsp_load) begin
         rsp_base_ff   <= alloc_base;
         rsp_status_ff <= res.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSW'(rsp_base_ff);
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_EXTENTS))
      else $error("extent count beyond table depth");

   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) && ctl.last |=> (state_ff == S_FIN))
      else $error("ring pass did not end after one full turn");

   a_grow_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && res.grow |-> (count_ff < CW'(MAX_EXTENTS)))
      else $error("insert into a full extent table");

   a_req_width: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_PREP) && (RQW > 2*ADDR_BITS))
      else $error("accepted transaction did not start a pass");
`endif

endmodule

FILE: sim/tb_first_fit_extent_allocator.sv
// ----------------------------------------------------------------------------
// First-fit extent allocator testbench
// Drives allocate and free requests through the stream ports, predicts each
// response with a local copy of the extent table, and compares every field.
// ----------------------------------------------------------------------------
module tb_first_fit_extent_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_EXTENTS = 64;
   localparam int ADDR_BITS   = 20;
   localparam int SPACE       = 1 << ADDR_BITS;

   typedef struct packed {
      logic [19:0] alloc_base;
      logic [1:0]  status;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   first_fit_extent_allocator #(.MAX_EXTENTS(MAX_EXTENTS), .ADDR_BITS(ADDR_BITS)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: sorted free extents.
   longint        ext_start[MAX_EXTENTS];
   longint        ext_size[MAX_EXTENTS];
   int            ext_count;
   alloc_rsp_type pending_rsp[$];
   int            mismatches = 0;
   int            sent = 0;
   int            received = 0;
   int            n_free_ok = 0;
   int            n_alloc_ok = 0;
   int            n_full = 0;
   bit            idle_on = 1'b1;

   function automatic void drop_extent(int i);
      for (int k = i; k + 1 < ext_count; k++) begin
         ext_start[k] = ext_start[k+1];
         ext_size[k]  = ext_size[k+1];
      end
      ext_count--;
   endfunction

   function automatic alloc_rsp_type predict_alloc(longint len);
      alloc_rsp_type r;
      r = '{alloc_base: '0, status: ffea_pkg::ST_NO_FIT};
      if (len == 0) return r;
      for (int i = 0; i < ext_count; i++) begin
         if (ext_size[i] >= len) begin
            r.alloc_base = ext_start[i][19:0];
            r.status = ffea_pkg::ST_OK;
            if (ext_size[i] == len) drop_extent(i);
            else begin
               ext_start[i] += len;
               ext_size[i]  -= len;
            end
            return r;
         end
      end
      return r;
   endfunction

   function automatic logic [1:0] predict_free(longint b, longint len);
      longint e;
      int     p;
      bit     lo, hi;
      e = b + len;
      p = 0;
      if (len == 0 || e > SPACE) return ffea_pkg::ST_BAD_FREE;
      while (p < ext_count && ext_start[p] < b) p++;
      if (p > 0 && ext_start[p-1] + ext_size[p-1] > b) return ffea_pkg::ST_BAD_FREE;
      if (p < ext_count && ext_start[p] < e) return ffea_pkg::ST_BAD_FREE;
      lo = (p > 0) && (ext_start[p-1] + ext_size[p-1] == b);
      hi = (p < ext_count) && (ext_start[p] == e);
      if (lo && hi) begin
         ext_size[p-1] += len + ext_size[p];
         drop_extent(p);
      end else if (lo) begin
         ext_size[p-1] += len;
      end else if (hi) begin
         ext_start[p] = b;
         ext_size[p] += len;
      end else begin
         if (ext_count >= MAX_EXTENTS) return ffea_pkg::ST_FULL;
         for (int k = ext_count; k > p; k--) begin
            ext_start[k] = ext_start[k-1];
            ext_size[k]  = ext_size[k-1];
         end
         ext_start[p] = b;
         ext_size[p]  = len;
         ext_count++;
      end
      return ffea_pkg::ST_OK;
   endfunction

   // Sends one request and records the predicted response. The valid line
   // stays high between back-to-back requests and drops only while idling.
   task automatic send_request(logic func, longint b, longint len);
      alloc_rsp_type r;
      if (func == ffea_pkg::FUNC_ALLOC) r = predict_alloc(len[20:0]);
      else r = '{alloc_base: '0, status: predict_free(b[19:0], len[20:0])};
      if (r.status == ffea_pkg::ST_OK && func == ffea_pkg::FUNC_FREE) n_free_ok++;
      if (r.status == ffea_pkg::ST_OK && func == ffea_pkg::FUNC_ALLOC) n_alloc_ok++;
      if (r.status == ffea_pkg::ST_FULL) n_full++;
      pending_rsp = {pending_rsp, r};
      while (idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, len[20:0], b[19:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   always @(posedge clock) begin
      if (!reset) rsp_tready <= !(idle_on && $urandom_range(99) < 32);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         received++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h/%0d", rsp_tdata, rsp_tuser);
         end else begin
            alloc_rsp_type x;
            x = pending_rsp.pop_front();
            if (rsp_tdata !== {4'd0, x.alloc_base} || rsp_tuser !== x.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected base %h status %0d, got %h status %0d",
                           x.alloc_base, x.status, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   task automatic test_edges();
      send_request(ffea_pkg::FUNC_ALLOC, 0, 16);              // empty table
      send_request(ffea_pkg::FUNC_ALLOC, 0, 0);               // zero length allocate
      send_request(ffea_pkg::FUNC_FREE, 5, 0);                // zero length free
      send_request(ffea_pkg::FUNC_FREE, SPACE - 4, 8);        // beyond the space
      send_request(ffea_pkg::FUNC_FREE, 0, SPACE);            // whole space
      send_request(ffea_pkg::FUNC_FREE, 100, 10);             // overlap
      send_request(ffea_pkg::FUNC_ALLOC, 'hFFFFF, SPACE);     // exact fit empties table
      send_request(ffea_pkg::FUNC_FREE, 'hFFFFF, 1);
      send_request(ffea_pkg::FUNC_FREE, 100, 50);
      send_request(ffea_pkg::FUNC_FREE, 150, 50);             // merge below
      send_request(ffea_pkg::FUNC_FREE, 60, 40);              // merge above
      send_request(ffea_pkg::FUNC_FREE, 300, 10);
      send_request(ffea_pkg::FUNC_FREE, 200, 100);            // merge both
      send_request(ffea_pkg::FUNC_ALLOC, 0, 20);
      send_request(ffea_pkg::FUNC_ALLOC, 0, 1000);            // no fit
      send_request(ffea_pkg::FUNC_ALLOC, 0, 230);
      send_request(ffea_pkg::FUNC_ALLOC, 0, 1);
   endtask

   // Fills the table with isolated extents to reach the full case.
   task automatic test_full();
      for (int i = 0; i < MAX_EXTENTS + 3; i++)
         send_request(ffea_pkg::FUNC_FREE, 4096 + i * 64, 32);
      send_request(ffea_pkg::FUNC_FREE, 4096 + 32, 8);        // merge still allowed when full
      send_request(ffea_pkg::FUNC_FREE, 4096 + 64 * 70, 8);
      for (int i = 0; i < MAX_EXTENTS + 4; i++) send_request(ffea_pkg::FUNC_ALLOC, 0, 32);
   endtask

   task automatic test_random(int count);
      longint b, len;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) idle_on = 1'b0;
         if (i == count / 2 + 150) idle_on = 1'b1;
         b = $urandom_range(SPACE - 1);
         case ($urandom_range(9))
            0: len = $urandom_range(SPACE);
            1: len = $urandom_range(2097151);
            2, 3: len = $urandom_range(16, 1);
            default: len = $urandom_range(4096, 1);
         endcase
         if ($urandom_range(3) == 0 && ext_count > 0) begin
            // Free right next to an extent to exercise coalescing.
            int j;
            j = $urandom_range(ext_count - 1);
            b = $urandom_range(1) ? ext_start[j] + ext_size[j] : ext_start[j] - len;
            if (b < 0 || b >= SPACE) b = $urandom_range(SPACE - 1);
         end
         send_request($urandom_range(1) ? ffea_pkg::FUNC_FREE : ffea_pkg::FUNC_ALLOC, b, len);
      end
   endtask

   initial begin
      ext_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edges();
      test_full();
      test_random(1100);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (MAX_EXTENTS + 20) @(posedge clock);
      $display("sent %0d requests, %0d responses; %0d frees and %0d allocations succeeded,",
               sent, received, n_free_ok, n_alloc_ok);
      $display("table-full seen %0d times; %0d mismatches", n_full, mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("first_fit_extent_allocator test passed");
      else
         $display("first_fit_extent_allocator test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("first_fit_extent_allocator test failed");
      $finish;
   end
endmodule
